[rtl/core/sitda_pkg.sv]
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies; every module of the block imports this package.
`default_nettype none
package sitda_pkg;

	localparam logic [5:0] ASCII_ZERO  = 6'd48;
	localparam logic [5:0] ASCII_MINUS = 6'd45;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CONV,
		BK_SIGN,
		BK_DIGIT
	} bk_state_t;

endpackage
`default_nettype wire

[rtl/core/signed_int_to_decimal_ascii_top.sv]
// Top level of the signed integer to decimal ASCII converter.
// Instantiates sitda_front, sitda_queue and sitda_back; uses sitda_pkg.
//
// Pulse start with a value while busy is low; the text comes out one character
// per strobe cycle: a '-' for a negative value, then the decimal digits most
// significant first with no leading zeros, last_char high on the final one.
// The receiver cannot stall: each character is valid for exactly one cycle.
// The shift-and-add-3 loop converts one bit per cycle and the digit scan visits
// every BCD digit, emitting or dropping one per cycle. A two-entry queue lets
// up to three further values be taken while one converts. Nothing needs
// clearing after reset.
`default_nettype none
module signed_int_to_decimal_ascii_top import sitda_pkg::*; #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic                       strobe,
	output logic [5:0]                 character,
	output logic                       last_char
);

	logic                push;
	logic [VALUE_BITS:0] push_data;
	logic                full;
	logic                pop;
	logic                q_valid;
	logic [VALUE_BITS:0] q_data;

	sitda_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	sitda_queue #(.WIDTH(VALUE_BITS + 1)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.valid     (q_valid),
		.data      (q_data)
	);

	sitda_back #(.VALUE_BITS(VALUE_BITS), .MAX_DIGITS(MAX_DIGITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop),
		.strobe    (strobe),
		.character (character),
		.last_char (last_char)
	);

endmodule
`default_nettype wire

[rtl/core/sitda_front.sv]
// Front end: accepts a value, splits it into sign and unsigned magnitude.
// Holds one classified item until the queue takes it. Uses sitda_pkg.
`default_nettype none
module sitda_front import sitda_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic                       busy,
	input  wire logic                  full,
	output logic                       push,
	output logic [VALUE_BITS:0]        push_data
);

	logic                  valid_s1;
	logic                  neg_s1;
	logic [VALUE_BITS-1:0] mag_s1;
	logic                  accept;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag;

	assign push      = valid_s1 && !full;
	assign busy      = valid_s1 && full;
	assign accept    = start && !busy;
	assign push_data = {neg_s1, mag_s1};

	// Two's complement negate; the most negative value maps to its true magnitude.
	always_comb begin
		neg = value[VALUE_BITS-1];
		mag = neg ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_s1 <= neg;
			mag_s1 <= mag;
		end
	end

endmodule
`default_nettype wire

[rtl/core/sitda_queue.sv]
// Two-entry queue between the front end and the conversion engine.
// Plain registers, no package dependencies beyond the common import.
`default_nettype none
module sitda_queue import sitda_pkg::*; #(
	parameter int WIDTH = 33
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output logic [WIDTH-1:0]      data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

[rtl/core/sitda_back.sv]
// Back end: shift-and-add-3 binary to BCD, one bit per cycle, then a digit scan
// that drops leading zeros and drives at most one character per cycle. Uses sitda_pkg.
`default_nettype none
module sitda_back import sitda_pkg::*; #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_DIGITS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire logic [VALUE_BITS:0] q_data,
	output logic                   pop,
	output logic                   strobe,
	output logic [5:0]             character,
	output logic                   last_char
);

	localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);
	localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(MAX_DIGITS - 1);

	bk_state_t             state_q, state_d;
	logic [VALUE_BITS-1:0] bin_q;
	logic [3:0]            bcd_q [MAX_DIGITS];
	logic [3:0]            corr  [MAX_DIGITS];
	logic [3:0]            bcd_d [MAX_DIGITS];
	logic                  carry;
	logic                  neg_q;
	logic                  ovf_q;
	logic                  started_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic [3:0]            cur_digit;
	logic                  skip;
	logic                  emit;
	logic [5:0]            char_d;
	logic                  last_d;
	logic                  strobe_q;
	logic [5:0]            char_q;
	logic                  last_q;

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last_char = last_q;
	assign cur_digit = bcd_q[idx_q];
	// Leading zero: drop unless digits were lost above or this is the ones place.
	assign skip = (cur_digit == 4'd0) && !ovf_q && !started_q && (idx_q != '0);

	// Add-3 correction and one-bit shift of the BCD register.
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i] inside {[4'd5:4'd15]}) begin
				corr[i] = bcd_q[i] + 4'd3;
			end else begin
				corr[i] = bcd_q[i];
			end
		end
		bcd_d[0] = {corr[0][2:0], bin_q[VALUE_BITS-1]};
		for (int i = 1; i < MAX_DIGITS; i++) begin
			bcd_d[i] = {corr[i][2:0], corr[i-1][3]};
		end
		carry = corr[MAX_DIGITS-1][3];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					state_d = BK_CONV;
				end
			end
			BK_CONV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = neg_q ? BK_SIGN : BK_DIGIT;
				end
			end
			BK_SIGN: begin
				state_d = BK_DIGIT;
			end
			BK_DIGIT: begin
				if (!skip && idx_q == '0) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		emit   = 1'b0;
		char_d = ASCII_ZERO;
		last_d = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop = q_valid;
			end
			BK_SIGN: begin
				emit   = 1'b1;
				char_d = ASCII_MINUS;
			end
			BK_DIGIT: begin
				emit   = !skip;
				char_d = ASCII_ZERO + {2'b00, cur_digit};
				last_d = (idx_q == '0);
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			strobe_q  <= 1'b0;
			cnt_q     <= '0;
			idx_q     <= '0;
			started_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			case (state_q)
				BK_IDLE: begin
					cnt_q     <= '0;
					idx_q     <= IDX_TOP;
					started_q <= 1'b0;
					ovf_q     <= 1'b0;
				end
				BK_CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					ovf_q <= ovf_q | carry;
				end
				BK_DIGIT: begin
					if (!skip) begin
						started_q <= 1'b1;
					end
					if (idx_q != '0) begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		char_q <= char_d;
		last_q <= last_d;
		if (state_q == BK_IDLE && q_valid) begin
			neg_q <= q_data[VALUE_BITS];
			bin_q <= q_data[VALUE_BITS-1:0];
			for (int i = 0; i < MAX_DIGITS; i++) begin
				bcd_q[i] <= 4'd0;
			end
		end else if (state_q == BK_CONV) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= bcd_d;
		end
	end

endmodule
`default_nettype wire

[rtl/core/sitda_checker.sv]
// Port-level checks on the converter's character stream, bound to the top.
// Depends on sitda_pkg for the character codes.
`default_nettype none
module sitda_checker import sitda_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic [VALUE_BITS-1:0] value,
	input wire logic                  strobe,
	input wire logic [5:0]            character,
	input wire logic                  last_char
);

	logic unused_in;
	assign unused_in = start ^ busy ^ (^value);

	// Only a minus sign or a decimal digit leaves the block.
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (character == ASCII_MINUS) ||
			(character >= ASCII_ZERO && character <= ASCII_ZERO + 6'd9))
		else $error("character code out of range");

	// A minus sign never ends a run.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && character == ASCII_MINUS) |-> !last_char)
		else $error("minus sign flagged as last character");

	// A minus sign only opens a run, never follows the same run's characters.
	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && $past(strobe) && !$past(last_char)) |-> character != ASCII_MINUS)
		else $error("minus sign inside a run");

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker #(.VALUE_BITS(VALUE_BITS)) u_sitda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.value     (value),
	.strobe    (strobe),
	.character (character),
	.last_char (last_char)
);
`default_nettype wire
